### src/rs485_frame_checker_macros.svh
// Assertion macros used by the frame checker core RTL.
`ifndef RS485_FRAME_CHECKER_MACROS_SVH
`define RS485_FRAME_CHECKER_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define RSFC_ASSERT(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Condition in one cycle that implies another in the next cycle.
`define RSFC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/rsfc_pkg.sv
`default_nettype none

package rsfc_pkg;

  localparam logic [15:0] CRC_POLY     = 16'h1021;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [7:0]  END_MARK     = 8'hFF;
  localparam int          OVERHEAD     = 6;
  localparam int          HEADER_BYTES = 3;

  // Reset values of the configuration registers
  localparam logic [7:0] MASTER_ADDR_RST = 8'd1;
  localparam logic [7:0] SLAVE1_ADDR_RST = 8'd10;
  localparam logic [7:0] SLAVE2_ADDR_RST = 8'd11;
  localparam logic [6:0] FRAME_LEN_RST   = 7'd16;

  typedef enum logic [1:0] {
    REG_MASTER_ADDR = 2'd0,
    REG_SLAVE1_ADDR = 2'd1,
    REG_SLAVE2_ADDR = 2'd2,
    REG_FRAME_LEN   = 2'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    STAT_PENDING       = 3'd0,
    STAT_ACCEPTED      = 3'd1,
    STAT_NOT_ADDRESSED = 3'd2,
    STAT_LEN_TOO_LARGE = 3'd3,
    STAT_BAD_END       = 3'd4,
    STAT_CRC_ERROR     = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] master_address;
    logic [7:0] first_slave_address;
    logic [7:0] second_slave_address;
    logic [6:0] frame_length;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       data_valid;
    logic       frame_done;
    status_t    status;
    logic [7:0] source_address;
  } result_t;

  // CRC-16/CCITT-FALSE update over one byte, MSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### src/rsfc_core.sv
`default_nettype none

module rsfc_core #(
  parameter int MAX_FRAME = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire rsfc_pkg::cfg_t   cfg,
  input  wire logic [7:0]       rx_byte,
  input  wire logic             restart,
  output rsfc_pkg::result_t     res
);
  import rsfc_pkg::*;

  `include "rs485_frame_checker_macros.svh"

  localparam int PW  = (MAX_FRAME > 2) ? $clog2(MAX_FRAME) : 1;
  localparam int LCW = $clog2(MAX_FRAME + 1);
  localparam int LW  = (LCW > 7) ? LCW : 7;
  localparam int MW  = (LW > 8) ? LW : 8;

  // Frame state
  logic [PW-1:0] byte_position, byte_position_next;
  logic [15:0]   crc_register, crc_register_next;
  logic [7:0]    destination_seen, destination_seen_next;
  logic [7:0]    source_seen, source_seen_next;
  logic [7:0]    payload_count, payload_count_next;
  logic [7:0]    received_crc_high, received_crc_high_next;

  // Working values after an optional restart
  logic [PW-1:0] pos;
  logic [15:0]   crc_base, crc_upd;
  logic [7:0]    dst_base, dst_upd;
  logic [7:0]    src_base, src_upd;
  logic [7:0]    cnt_base, cnt_upd;
  logic [7:0]    rch_base, rch_upd;

  logic [LW-1:0] len_raw, len, pos_ext;
  logic [MW-1:0] pos_wide, cnt_wide, room;
  logic          src_ok, done, valid;
  status_t       status;

  // Clamp the frame length into the supported range
  always_comb begin
    len_raw = LW'(cfg.frame_length);
    if (len_raw < LW'(OVERHEAD)) begin
      len = LW'(OVERHEAD);
    end else if (len_raw > LW'(MAX_FRAME)) begin
      len = LW'(MAX_FRAME);
    end else begin
      len = len_raw;
    end
  end

  // Drop a partial frame on restart
  always_comb begin
    if (restart) begin
      pos      = '0;
      crc_base = CRC_INIT;
      dst_base = '0;
      src_base = '0;
      cnt_base = '0;
      rch_base = '0;
    end else begin
      pos      = byte_position;
      crc_base = crc_register;
      dst_base = destination_seen;
      src_base = source_seen;
      cnt_base = payload_count;
      rch_base = received_crc_high;
    end
  end

  // Classify the byte by its position and update the frame fields
  always_comb begin
    pos_ext  = LW'(pos);
    pos_wide = MW'(pos);
    cnt_wide = MW'(cnt_base);
    room     = MW'(len - LW'(OVERHEAD));
    src_ok   = (src_base == cfg.first_slave_address) ||
               (src_base == cfg.second_slave_address);
    crc_upd  = crc_base;
    dst_upd  = dst_base;
    src_upd  = src_base;
    cnt_upd  = cnt_base;
    rch_upd  = rch_base;
    done     = 1'b0;
    valid    = 1'b0;
    status   = STAT_PENDING;
    if (pos_ext >= len - LW'(1)) begin
      done = 1'b1;
      if (!src_ok || dst_base != cfg.master_address) begin
        status = STAT_NOT_ADDRESSED;
      end else if (cnt_wide > room) begin
        status = STAT_LEN_TOO_LARGE;
      end else if (rx_byte != END_MARK) begin
        status = STAT_BAD_END;
      end else if (crc_base != 16'h0000) begin
        status = STAT_CRC_ERROR;
      end else begin
        status = STAT_ACCEPTED;
      end
    end else if (pos_ext == len - LW'(2)) begin
      // zero here means the received CRC matches
      crc_upd = crc_base ^ {rch_base, rx_byte};
    end else if (pos_ext == len - LW'(3)) begin
      rch_upd = rx_byte;
    end else begin
      crc_upd = crc16_byte(crc_base, rx_byte);
      if (pos_ext == LW'(0)) begin
        dst_upd = rx_byte;
      end else if (pos_ext == LW'(1)) begin
        src_upd = rx_byte;
      end else if (pos_ext == LW'(2)) begin
        cnt_upd = rx_byte;
      end else if (pos_wide - MW'(HEADER_BYTES) < cnt_wide) begin
        valid = 1'b1;
      end
    end
  end

  // Build the result item
  always_comb begin
    res.data_byte      = rx_byte;
    res.data_valid     = valid;
    res.frame_done     = done;
    res.status         = status;
    res.source_address = (pos_ext == LW'(0)) ? 8'h00 : src_upd;
  end

  // Clear the state after the last byte, else advance
  always_comb begin
    if (done) begin
      byte_position_next     = '0;
      crc_register_next      = CRC_INIT;
      destination_seen_next  = '0;
      source_seen_next       = '0;
      payload_count_next     = '0;
      received_crc_high_next = '0;
    end else begin
      byte_position_next     = pos + PW'(1);
      crc_register_next      = crc_upd;
      destination_seen_next  = dst_upd;
      source_seen_next       = src_upd;
      payload_count_next     = cnt_upd;
      received_crc_high_next = rch_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      crc_register      <= CRC_INIT;
      destination_seen  <= '0;
      source_seen       <= '0;
      payload_count     <= '0;
      received_crc_high <= '0;
    end else if (step) begin
      byte_position     <= byte_position_next;
      crc_register      <= crc_register_next;
      destination_seen  <= destination_seen_next;
      source_seen       <= source_seen_next;
      payload_count     <= payload_count_next;
      received_crc_high <= received_crc_high_next;
    end
  end

  `RSFC_ASSERT_NEXT(a_clear_after_done, step && res.frame_done,
    byte_position == '0 && crc_register == CRC_INIT, "state not cleared after frame end")
  `RSFC_ASSERT(a_status_on_done, (res.status != STAT_PENDING) == res.frame_done,
    "status and frame end disagree")
  `RSFC_ASSERT(a_valid_not_last, !(res.data_valid && res.frame_done),
    "payload mark on last byte")

endmodule

`default_nettype wire

### src/rs485_frame_checker.sv
`default_nettype none

// RS-485 fixed-length frame checker.
// Input channel s_*: one received byte per item in s_tdata[7:0]; s_tuser set
// marks the byte as the first of a new frame and drops any partial frame.
// Output channel m_*: exactly one item per input byte. m_tdata carries the
// byte, the frame status and the source address; m_tuser marks a payload
// byte within the declared length; m_tlast marks the last byte of the frame,
// the only item whose status is not pending.
// Path: an item passes through an input register, then the position decode
// and the byte-wide CRC-16 update, then the result register. Throughput is
// one item per cycle while m_tready stays high; the CRC update over one byte
// is the longest path.
// When m_tready is low, the result register holds and the input register
// still takes one more item; s_tready drops only when both are full.
// Reset clears both registers, the frame state (CRC back to 0xFFFF) and
// loads the default configuration. The cfg port writes a register at any
// edge with cfg_we high; write it only while no item is in flight.
module rs485_frame_checker #(
  parameter int MAX_FRAME = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  wire logic        s_tuser,   // [0] restart
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [7:0] data_byte, [10:8] status, [18:11] source_address
  output logic             m_tuser,   // [0] data_valid
  output logic             m_tlast,   // frame_done
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);
  import rsfc_pkg::*;

  cfg_t       cfg;
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_restart;
  logic       advance;
  result_t    res;
  result_t    out_res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.master_address       <= MASTER_ADDR_RST;
      cfg.first_slave_address  <= SLAVE1_ADDR_RST;
      cfg.second_slave_address <= SLAVE2_ADDR_RST;
      cfg.frame_length         <= FRAME_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        REG_MASTER_ADDR: cfg.master_address       <= cfg_data;
        REG_SLAVE1_ADDR: cfg.first_slave_address  <= cfg_data;
        REG_SLAVE2_ADDR: cfg.second_slave_address <= cfg_data;
        REG_FRAME_LEN:   cfg.frame_length         <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Move the held item into the result register when it is free
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte    <= s_tdata;
      in_restart <= s_tuser;
    end
  end

  rsfc_core #(
    .MAX_FRAME (MAX_FRAME)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .cfg     (cfg),
    .rx_byte (in_byte),
    .restart (in_restart),
    .res     (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_tdata = {5'b00000, out_res.source_address, out_res.status, out_res.data_byte};
  assign m_tuser = out_res.data_valid;
  assign m_tlast = out_res.frame_done;

endmodule

`default_nettype wire
